// File: design/closest_pair_search_core_defines.svh
// Assertion macros shared by the closest pair search checker.
`ifndef CLOSEST_PAIR_SEARCH_CORE_DEFINES_SVH
`define CLOSEST_PAIR_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("closest pair search: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("closest pair search: next-cycle check failed");

`endif

// File: design/cps_pkg.sv
// Shared types and constants for the closest pair search core.
package cps_pkg;

    localparam int XW    = 16;  // port coordinate width
    localparam int IDXW  = 10;  // port index width
    localparam int DISTW = 33;  // port squared distance width

    typedef struct packed {
        logic signed [XW-1:0] x_coord;
        logic signed [XW-1:0] y_coord;
        logic                 last_point;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [IDXW-1:0]      first_index;
        logic [IDXW-1:0]      second_index;
        logic signed [XW-1:0] first_x;
        logic signed [XW-1:0] first_y;
        logic signed [XW-1:0] second_x;
        logic signed [XW-1:0] second_y;
        logic [DISTW-1:0]     min_sq_distance;
        logic                 overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_RD_J,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_row;    // read fetches the row point i, not a pair partner
        logic clr_best;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic busy;
    } t_dp_sts;

endpackage

// File: design/cps_stream_if.sv
// Valid/ready channel interfaces for point input and pair result output.
interface cps_in_if
    import cps_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cps_out_if
    import cps_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/cps_ctrl.sv
// Controller: point loading, pair scan sequencing and result handshake.
module cps_ctrl
    import cps_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_last,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output t_dp_cmd                       o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0] o_wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0] o_rd_addr,
    output logic [$clog2(MAX_POINTS)-1:0] o_row_idx,
    input  t_dp_sts                       i_sts,
    output logic                          o_overflow
);

    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CNW = $clog2(MAX_POINTS + 1);

    t_state          r_state, n_state;
    logic [CNW-1:0]  r_count, n_count;
    logic            r_ovf,   n_ovf;
    logic [IW-1:0]   r_i,     n_i;
    logic [IW-1:0]   r_j,     n_j;
    logic            full;
    logic [CNW-1:0]  cnt_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign full      = (r_count == CNW'(MAX_POINTS));
    assign cnt_after = full ? r_count : r_count + CNW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_rd_addr   = r_j;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!full) begin
                        o_cmd.wr_en = 1'b1;
                        n_count     = cnt_after;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        o_cmd.clr_best = 1'b1;
                        n_i            = '0;
                        n_state        = (cnt_after >= CNW'(2)) ? ST_RD_I : ST_DRAIN;
                    end
                end
            end
            ST_RD_I: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_row = 1'b1;
                o_rd_addr    = r_i;
                n_j          = r_i + IW'(1);
                n_state      = ST_RD_J;
            end
            ST_RD_J: begin
                o_cmd.rd_en = 1'b1;
                if (CNW'(r_j) == r_count - CNW'(1)) begin
                    if (CNW'(r_i) == r_count - CNW'(2)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = ST_RD_I;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_wr_addr  = r_count[IW-1:0];
    assign o_row_idx  = r_i;
    assign o_overflow = r_ovf;

endmodule

// File: design/cps_dpath.sv
// Datapath: point memory, distance pipeline and best-pair registers.
module cps_dpath
    import cps_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  logic signed [XW-1:0]          i_wr_x,
    input  logic signed [XW-1:0]          i_wr_y,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_POINTS)-1:0] i_row_idx,
    output t_dp_sts                       o_sts,
    output logic                          o_found,
    output logic [IDXW-1:0]               o_first_index,
    output logic [IDXW-1:0]               o_second_index,
    output logic signed [XW-1:0]          o_first_x,
    output logic signed [XW-1:0]          o_first_y,
    output logic signed [XW-1:0]          o_second_x,
    output logic signed [XW-1:0]          o_second_y,
    output logic [DISTW-1:0]              o_min_sq_distance
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int AW = CW + 1;         // |difference|
    localparam int DW = 2 * AW + 1;     // sum of two squares

    // point memory, {x, y}
    logic [2*CW-1:0] mem [MAX_POINTS];
    logic [2*CW-1:0] r_rd_data;

    logic [CW+XW-1:0] wx_ext, wy_ext;

    // read tag stage
    logic            r_rd_v;
    logic            r_rd_row;
    logic [IW-1:0]   r_rd_i, r_rd_j;

    logic signed [CW-1:0] r_pix, r_piy;
    logic signed [CW-1:0] rx, ry;
    logic signed [AW-1:0] dx, dy;
    logic [AW-1:0]        ax, ay;

    // stage 1: absolute differences
    logic                 r_s1_v;
    logic [AW-1:0]        r_s1_ax, r_s1_ay;
    logic signed [CW-1:0] r_s1_xi, r_s1_yi, r_s1_xj, r_s1_yj;
    logic [IW-1:0]        r_s1_i, r_s1_j;

    // stage 2: squares
    logic                 r_s2_v;
    logic [2*AW-1:0]      r_s2_sqx, r_s2_sqy;
    logic signed [CW-1:0] r_s2_xi, r_s2_yi, r_s2_xj, r_s2_yj;
    logic [IW-1:0]        r_s2_i, r_s2_j;

    logic [DW-1:0]        sum;
    logic                 take;

    // best pair so far
    logic                 r_have;
    logic [DW-1:0]        r_best;
    logic [IW-1:0]        r_bi, r_bj;
    logic signed [CW-1:0] r_bxi, r_byi, r_bxj, r_byj;

    logic [IW+IDXW-1:0]        bi_ext, bj_ext;
    logic signed [CW+XW-1:0]   bxi_ext, byi_ext, bxj_ext, byj_ext;
    logic [DW+DISTW-1:0]       best_ext;

    // low CW bits of the port value; zero-extended when CW is wider than the port
    assign wx_ext = (CW+XW)'($unsigned(i_wr_x));
    assign wy_ext = (CW+XW)'($unsigned(i_wr_y));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_wr_addr] <= {wx_ext[CW-1:0], wy_ext[CW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            r_s1_v <= r_rd_v && !r_rd_row;
            r_s2_v <= r_s1_v;
            if (i_cmd.clr_best) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
        end
    end

    assign rx = r_rd_data[2*CW-1:CW];
    assign ry = r_rd_data[CW-1:0];
    assign dx = AW'(r_pix) - AW'(rx);
    assign dy = AW'(r_piy) - AW'(ry);
    assign ax = dx[AW-1] ? AW'(-dx) : AW'(dx);
    assign ay = dy[AW-1] ? AW'(-dy) : AW'(dy);

    assign sum  = DW'(r_s2_sqx) + DW'(r_s2_sqy);
    assign take = r_s2_v && (!r_have || sum < r_best);

    always_ff @(posedge i_clk) begin
        r_rd_row <= i_cmd.rd_row;
        r_rd_i   <= i_row_idx;
        r_rd_j   <= i_rd_addr;

        if (r_rd_v && r_rd_row) begin
            r_pix <= rx;
            r_piy <= ry;
        end

        r_s1_ax <= ax;
        r_s1_ay <= ay;
        r_s1_xi <= r_pix;
        r_s1_yi <= r_piy;
        r_s1_xj <= rx;
        r_s1_yj <= ry;
        r_s1_i  <= r_rd_i;
        r_s1_j  <= r_rd_j;

        r_s2_sqx <= (2*AW)'(r_s1_ax) * (2*AW)'(r_s1_ax);
        r_s2_sqy <= (2*AW)'(r_s1_ay) * (2*AW)'(r_s1_ay);
        r_s2_xi  <= r_s1_xi;
        r_s2_yi  <= r_s1_yi;
        r_s2_xj  <= r_s1_xj;
        r_s2_yj  <= r_s1_yj;
        r_s2_i   <= r_s1_i;
        r_s2_j   <= r_s1_j;

        // cleared fields are what a set with fewer than two points reports
        if (i_cmd.clr_best) begin
            r_best <= '0;
            r_bi   <= '0;
            r_bj   <= '0;
            r_bxi  <= '0;
            r_byi  <= '0;
            r_bxj  <= '0;
            r_byj  <= '0;
        end else if (take) begin
            r_best <= sum;
            r_bi   <= r_s2_i;
            r_bj   <= r_s2_j;
            r_bxi  <= r_s2_xi;
            r_byi  <= r_s2_yi;
            r_bxj  <= r_s2_xj;
            r_byj  <= r_s2_yj;
        end
    end

    assign o_sts.busy = r_rd_v | r_s1_v | r_s2_v;

    assign bi_ext   = (IW+IDXW)'(r_bi);
    assign bj_ext   = (IW+IDXW)'(r_bj);
    assign bxi_ext  = (CW+XW)'(r_bxi);
    assign byi_ext  = (CW+XW)'(r_byi);
    assign bxj_ext  = (CW+XW)'(r_bxj);
    assign byj_ext  = (CW+XW)'(r_byj);
    assign best_ext = (DW+DISTW)'(r_best);

    assign o_found           = r_have;
    assign o_first_index     = bi_ext[IDXW-1:0];
    assign o_second_index    = bj_ext[IDXW-1:0];
    assign o_first_x         = $signed(bxi_ext[XW-1:0]);
    assign o_first_y         = $signed(byi_ext[XW-1:0]);
    assign o_second_x        = $signed(bxj_ext[XW-1:0]);
    assign o_second_y        = $signed(byj_ext[XW-1:0]);
    assign o_min_sq_distance = best_ext[DISTW-1:0];

endmodule

// File: design/closest_pair_search_core.sv
// Points load one per cycle while i_pt.ready is high, which is the whole loading phase. The
// transaction marked last_point starts a brute-force search over the N stored points when N is at
// least two: each row i costs one memory read for point i plus one read per partner j, all through
// the single read port of the point memory, and the distance pipeline then drains. The result
// then waits on o_res until taken, and the next point is accepted in the cycle after that. The
// point memory needs no clearing after reset.
module closest_pair_search_core
    import cps_pkg::*;
#(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cps_in_if.sink           i_pt,
    cps_out_if.source        o_res
);

    localparam int IW = $clog2(MAX_POINTS);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] row_idx;
    logic          overflow;

    cps_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .i_in_last   (i_pt.payload.last_point),
        .o_in_ready  (i_pt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_row_idx   (row_idx),
        .i_sts       (sts),
        .o_overflow  (overflow)
    );

    cps_dpath #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_wr_addr         (wr_addr),
        .i_wr_x            (i_pt.payload.x_coord),
        .i_wr_y            (i_pt.payload.y_coord),
        .i_rd_addr         (rd_addr),
        .i_row_idx         (row_idx),
        .o_sts             (sts),
        .o_found           (o_res.payload.found),
        .o_first_index     (o_res.payload.first_index),
        .o_second_index    (o_res.payload.second_index),
        .o_first_x         (o_res.payload.first_x),
        .o_first_y         (o_res.payload.first_y),
        .o_second_x        (o_res.payload.second_x),
        .o_second_y        (o_res.payload.second_y),
        .o_min_sq_distance (o_res.payload.min_sq_distance)
    );

    assign o_res.payload.overflow = overflow;

endmodule

// File: design/cps_checker.sv
// Port-level checker for the closest pair search core, bound to the top level.
`include "closest_pair_search_core_defines.svh"

module cps_checker
    import cps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    logic empty_pair_zero;

    assign empty_pair_zero = (i_out_item.first_index == '0) &&
                             (i_out_item.second_index == '0) &&
                             (i_out_item.min_sq_distance == '0);

    // a pending result holds until taken
    `CPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // loading and result delivery never overlap
    `CPS_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, 1'b1, !(i_in_ready && i_out_valid))

    // after the result transaction the block loads again
    `CPS_ASSERT_NEXT(a_reload, i_clk, i_rst_n, i_out_valid && i_out_ready, i_in_ready)

    // no pair: pair indices and distance read as zero
    `CPS_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, i_out_valid && !i_out_item.found, empty_pair_zero)

endmodule

bind closest_pair_search_core cps_checker u_cps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_item  (o_res.payload)
);
